// File: src/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define CNS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define CNS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/cns_pkg.sv
// shared constants, codes and types of the cutoff neighbor search unit
package cns_pkg;

    localparam int MAX_PARTNERS = 32;
    localparam int COORD_BITS   = 24;

    localparam int ID_W      = 16;
    localparam int SLOT_W    = 5;
    localparam int CNT_W     = 6;
    localparam int CUT_W     = 51;
    localparam int CFG_IDX_W = 1;

    localparam int IDX_W = (MAX_PARTNERS > 1) ? $clog2(MAX_PARTNERS) : 1;
    // |a - b| of two coordinates stays below 2^COORD_BITS
    localparam int MAG_W = COORD_BITS;
    localparam int SQ_W  = 2 * MAG_W;
    localparam int SUM_W = SQ_W + 2;
    localparam int CMP_W = (SUM_W > CUT_W) ? SUM_W : CUT_W;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CUTOFF_SQ     = 1'b0,
        CFG_PARTNER_COUNT = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic             load;
        logic             query;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             emit_end;
    } t_dp_cmd;

    typedef struct packed {
        logic pipe_busy;
    } t_dp_status;

    typedef struct packed {
        logic [ID_W-1:0]              id;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } t_partner;

endpackage

// File: src/cns_ctrl.sv
// controller: issues partner loads, walks the partner slots of a query and closes it with the end item
module cns_ctrl
    import cns_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_opcode,
    input  logic [CNT_W-1:0] i_partner_count,
    input  t_dp_status       i_status,
    output t_dp_cmd          o_cmd,
    output logic             o_busy
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_last_idx, n_last_idx;
    logic [CNT_W-1:0] w_count;

    // counts above the store depth are clipped
    assign w_count = (i_partner_count > CNT_W'(MAX_PARTNERS)) ?
                     CNT_W'(MAX_PARTNERS) : i_partner_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_idx      <= '0;
            r_last_idx <= '0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_last_idx <= n_last_idx;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_last_idx = r_last_idx;
        o_cmd      = '0;
        o_busy     = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    if (i_opcode == OP_QUERY) begin
                        o_cmd.query = 1'b1;
                        n_idx       = '0;
                        n_last_idx  = w_count - CNT_W'(1);
                        n_state     = (w_count == '0) ? ST_FLUSH : ST_RUN;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            ST_RUN: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = r_idx[IDX_W-1:0];
                n_idx         = r_idx + CNT_W'(1);
                if (r_idx == r_last_idx) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                // end item goes out only after the last compare has left the pipe
                if (!i_status.pipe_busy) begin
                    o_cmd.emit_end = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: src/cns_dpath.sv
// datapath: partner store, pipelined squared-distance check and result register
module cns_dpath
    import cns_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_dp_cmd                      i_cmd,
    output t_dp_status                   o_status,
    input  logic [SLOT_W-1:0]            i_slot,
    input  logic [ID_W-1:0]              i_atom_id,
    input  logic signed [COORD_BITS-1:0] i_pos_x,
    input  logic signed [COORD_BITS-1:0] i_pos_y,
    input  logic signed [COORD_BITS-1:0] i_pos_z,
    input  logic [CUT_W-1:0]             i_cutoff_sq,
    output logic                         o_strobe,
    output logic [ID_W-1:0]              o_central_id,
    output logic [ID_W-1:0]              o_neighbor_id,
    output logic                         o_is_neighbor,
    output logic [CNT_W-1:0]             o_neighbor_total,
    output logic                         o_last
);

    function automatic logic [MAG_W-1:0] abs_diff(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        logic signed [COORD_BITS:0] d;
        begin
            d = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
            if (d < 0) begin
                abs_diff = MAG_W'(-d);
            end else begin
                abs_diff = MAG_W'(d);
            end
        end
    endfunction

    t_partner mem [MAX_PARTNERS];

    t_partner                     r_center;
    logic [CNT_W-1:0]             r_found;

    t_partner                     r_rd;
    logic                         r_v1;
    logic [ID_W-1:0]              r_id2;
    logic [MAG_W-1:0]             r_mag_x, r_mag_y, r_mag_z;
    logic                         r_v2;
    logic [ID_W-1:0]              r_id3;
    logic [SQ_W-1:0]              r_sq_x, r_sq_y, r_sq_z;
    logic                         r_v3;

    logic [SUM_W-1:0]             w_sum;
    logic                         w_hit;

    // partner store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && ({1'b0, i_slot} < (SLOT_W + 1)'(MAX_PARTNERS))) begin
            mem[IDX_W'(i_slot)] <= '{id: i_atom_id, x: i_pos_x, y: i_pos_y, z: i_pos_z};
        end
        if (i_cmd.rd_en) begin
            r_rd <= mem[i_cmd.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.query) begin
            r_center <= '{id: i_atom_id, x: i_pos_x, y: i_pos_y, z: i_pos_z};
        end
        r_id2   <= r_rd.id;
        r_mag_x <= abs_diff(r_center.x, r_rd.x);
        r_mag_y <= abs_diff(r_center.y, r_rd.y);
        r_mag_z <= abs_diff(r_center.z, r_rd.z);
        r_id3   <= r_id2;
        r_sq_x  <= r_mag_x * r_mag_x;
        r_sq_y  <= r_mag_y * r_mag_y;
        r_sq_z  <= r_mag_z * r_mag_z;
    end

    // sum of squares cannot overflow SUM_W, so no saturation is needed
    assign w_sum = SUM_W'(r_sq_x) + SUM_W'(r_sq_y) + SUM_W'(r_sq_z);
    assign w_hit = r_v3 && (w_sum != '0) && (CMP_W'(w_sum) <= CMP_W'(i_cutoff_sq));

    assign o_status.pipe_busy = r_v1 | r_v2 | r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_found  <= '0;
            o_strobe <= 1'b0;
        end else begin
            r_v1     <= i_cmd.rd_en;
            r_v2     <= r_v1;
            r_v3     <= r_v2;
            o_strobe <= w_hit | i_cmd.emit_end;
            if (i_cmd.query) begin
                r_found <= '0;
            end else if (w_hit) begin
                r_found <= r_found + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_hit) begin
            o_central_id     <= r_center.id;
            o_neighbor_id    <= r_id3;
            o_is_neighbor    <= 1'b1;
            o_neighbor_total <= '0;
            o_last           <= 1'b0;
        end else if (i_cmd.emit_end) begin
            o_central_id     <= r_center.id;
            o_neighbor_id    <= '0;
            o_is_neighbor    <= 1'b0;
            o_neighbor_total <= r_found;
            o_last           <= 1'b1;
        end
    end

endmodule

// File: src/cutoff_neighbor_search_unit.sv
// top level of the cutoff neighbor search unit
// A load item (opcode 0) writes a partner's id and Q8.16 position into a slot; busy stays
// low. A query item (opcode 1) compares the central atom with slots 0 to n-1, n being
// partner_count clipped to 32, one slot per cycle through a single squared-distance
// pipeline fed by one read port of the partner store; busy is high until the query ends.
// Each partner with 0 < d^2 <= cutoff_sq yields a neighbor item, in slot order, once its
// slot has passed the read, magnitude, square and output registers; an end
// item with the neighbor count and last set follows in the first cycle that busy is low.
// Every item is on the outputs for exactly one cycle, marked by o_strobe, and must be taken
// then. Configuration writes are always ready and belong in idle periods only.
`include "assert_macros.svh"

module cutoff_neighbor_search_unit
    import cns_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic                         i_opcode,
    input  logic [SLOT_W-1:0]            i_slot,
    input  logic [ID_W-1:0]              i_atom_id,
    input  logic signed [COORD_BITS-1:0] i_pos_x,
    input  logic signed [COORD_BITS-1:0] i_pos_y,
    input  logic signed [COORD_BITS-1:0] i_pos_z,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CUT_W-1:0]             i_cfg_data,
    output logic                         o_strobe,
    output logic [ID_W-1:0]              o_central_id,
    output logic [ID_W-1:0]              o_neighbor_id,
    output logic                         o_is_neighbor,
    output logic [CNT_W-1:0]             o_neighbor_total,
    output logic                         o_last
);

    logic [CUT_W-1:0] r_cutoff_sq;
    logic [CNT_W-1:0] r_partner_count;
    t_dp_cmd          w_cmd;
    t_dp_status       w_status;

    logic             w_end_item;
    logic             w_end_ok;
    logic             w_nbr_item;
    logic             w_nbr_ok;
    logic             w_query_acc;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff_sq     <= '0;
            r_partner_count <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_CUTOFF_SQ:     r_cutoff_sq     <= i_cfg_data;
                CFG_PARTNER_COUNT: r_partner_count <= i_cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    cns_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .i_opcode        (i_opcode),
        .i_partner_count (r_partner_count),
        .i_status        (w_status),
        .o_cmd           (w_cmd),
        .o_busy          (o_busy)
    );

    cns_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_slot           (i_slot),
        .i_atom_id        (i_atom_id),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_pos_z          (i_pos_z),
        .i_cutoff_sq      (r_cutoff_sq),
        .o_strobe         (o_strobe),
        .o_central_id     (o_central_id),
        .o_neighbor_id    (o_neighbor_id),
        .o_is_neighbor    (o_is_neighbor),
        .o_neighbor_total (o_neighbor_total),
        .o_last           (o_last)
    );

    assign w_end_item  = o_strobe && o_last;
    assign w_end_ok    = !o_is_neighbor && (o_neighbor_id == '0);
    assign w_nbr_item  = o_strobe && o_is_neighbor;
    assign w_nbr_ok    = o_busy && !o_last && (o_neighbor_total == '0);
    assign w_query_acc = i_start && !o_busy && (i_opcode == OP_QUERY);

    `CNS_ASSERT_IMP(a_end_shape, w_end_item, w_end_ok, "end item carries a neighbor")
    `CNS_ASSERT_IMP(a_nbr_in_query, w_nbr_item, w_nbr_ok, "neighbor item outside a query")
    `CNS_ASSERT_NEXT(a_query_busy, w_query_acc, o_busy, "query accepted but unit not busy")
    `CNS_ASSERT_NEXT(a_end_gap, w_end_item, !o_strobe, "item right after end item")

endmodule
